@@ rtl/pfs_pkg.sv @@
// Package for the periodic frame scheduler: field widths, command and status codes,
// and the entry and cell control types shared by the table cells and the top level.
// No dependencies.
package pfs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 29;
    localparam int PERIOD_W = 24;
    localparam int TIME_W   = 48;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int TOTAL_W  = 5;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;

    // One table entry as held by a cell.
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   last_sent;
    } entry_t;

    // Per-cell update controls; at most one is set in a cycle.
    typedef struct packed {
        logic wr;      // load the entry being appended
        logic shift;   // load the entry of the next cell
        logic stamp;   // set last-sent to the current tick time
    } cell_ctrl_t;

endpackage

@@ rtl/pfs_cell.sv @@
// One cell of the scheduler table: holds a single entry, checks it against the
// remove key and the tick time, and can take over its neighbor's entry.
// Depends on pfs_pkg.
module pfs_cell
    import pfs_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  entry_t            wr_entry,
    input  entry_t            next_entry,
    input  logic [TIME_W-1:0] now,
    input  logic [ID_W-1:0]   key_id,
    output entry_t            entry,
    output logic              match,
    output logic              due
);

    entry_t            entry_reg;
    entry_t            entry_next;
    logic [TIME_W-1:0] elapsed;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr)
        begin
            entry_next = wr_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.stamp)
        begin
            entry_next.last_sent = now;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Elapsed time wraps modulo the width of the time field.
    assign elapsed = now - entry_reg.last_sent;
    assign due     = (elapsed >= TIME_W'(entry_reg.period));
    assign match   = (entry_reg.id == key_id);
    assign entry   = entry_reg;

endmodule

@@ rtl/periodic_frame_scheduler.sv @@
// Top level of the periodic frame scheduler: command sequencer, result staging
// and a row of pfs_cell table cells. Depends on pfs_pkg and pfs_cell.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall   | cmd, can_id, interval_ms, now_ms
//  out     | output    | out_valid/out_stall | kind, status, due_slot, due_id,
//          |           |                     | last_of_run, entry_total
//
// For add and clear the table is updated when the word is accepted, and the status
// word is held in the pending register and passed to the output register from S_LAST.
// Remove and tick walk the table one cell per cycle; the scan over the cells sets
// the rate, and a stalled output holds a tick scan at the next due entry.
// Reset empties the table at once (entry count zero); no clearing pass is needed.
// A new input word is accepted whenever the sequencer is idle, even if the output
// register still holds a word that has not been taken.
module periodic_frame_scheduler
    import pfs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [ID_W-1:0]     can_id,
    input  logic [PERIOD_W-1:0] interval_ms,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   due_slot,
    output logic [ID_W-1:0]     due_id,
    output logic                last_of_run,
    output logic [TOTAL_W-1:0]  entry_total
);

    // The count can hold the depth itself; the scan index runs up to the count.
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LAST = 3'b100
    } state_t;

    state_t              state_reg,      state_next;
    logic [CW-1:0]       count_reg,      count_next;
    logic [CW-1:0]       scan_idx_reg,   scan_idx_next;
    logic                op_remove_reg,  op_remove_next;
    logic                found_reg,      found_next;
    logic [ID_W-1:0]     key_id_reg,     key_id_next;
    logic [TIME_W-1:0]   now_reg,        now_next;

    // Pending result: a due entry is held here until the scan knows whether a later
    // entry follows it, which decides its last_of_run flag.
    logic                pend_valid_reg,  pend_valid_next;
    logic                pend_kind_reg,   pend_kind_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [SLOT_W-1:0]   pend_slot_reg,   pend_slot_next;
    logic [ID_W-1:0]     pend_id_reg,     pend_id_next;

    logic                out_valid_reg,  out_valid_next;
    logic                out_kind_reg,   out_kind_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg,   out_slot_next;
    logic [ID_W-1:0]     out_id_reg,     out_id_next;
    logic                out_last_reg,   out_last_next;
    logic [TOTAL_W-1:0]  out_total_reg,  out_total_next;

    cell_ctrl_t              cell_ctrl  [TABLE_DEPTH];
    entry_t                  cell_entry [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  cell_match;
    logic [TABLE_DEPTH-1:0]  cell_due;
    logic [TABLE_DEPTH-1:0]  sel;
    logic [TABLE_DEPTH-1:0]  wr_sel;
    entry_t                  wr_entry;

    logic                    sel_match;
    logic                    sel_due;
    logic [ID_W-1:0]         sel_id;
    logic                    out_free;
    logic                    add_wr;
    logic                    shift_en;
    logic                    stamp_en;

    // Last-sent starts at zero, so the appended entry is due on any tick at or past its period.
    assign wr_entry = '{id: can_id, period: interval_ms, last_sent: '0};

    // Row of table cells; each cell can take over the entry of the cell after it.
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        entry_t nb_entry;

        if (g == TABLE_DEPTH - 1)
        begin : g_tail
            assign nb_entry = cell_entry[g];
        end
        else
        begin : g_body
            assign nb_entry = cell_entry[g + 1];
        end

        assign sel[g]    = (scan_idx_reg == CW'(g));
        assign wr_sel[g] = (count_reg == CW'(g));

        pfs_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[g]),
            .wr_entry   (wr_entry),
            .next_entry (nb_entry),
            .now        (now_reg),
            .key_id     (key_id_reg),
            .entry      (cell_entry[g]),
            .match      (cell_match[g]),
            .due        (cell_due[g])
        );
    end

    // Pick out the cell under the scan pointer.
    always_comb
    begin
        sel_match = 1'b0;
        sel_due   = 1'b0;
        sel_id    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (sel[i])
            begin
                sel_match = sel_match | cell_match[i];
                sel_due   = sel_due | cell_due[i];
                sel_id    = sel_id | cell_entry[i].id;
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        op_remove_next   = op_remove_reg;
        found_next       = found_reg;
        key_id_next      = key_id_reg;
        now_next         = now_reg;
        pend_valid_next  = pend_valid_reg;
        pend_kind_next   = pend_kind_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_id_next     = pend_id_reg;
        out_valid_next   = out_valid_reg;
        out_kind_next    = out_kind_reg;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;
        out_total_next   = out_total_reg;
        add_wr           = 1'b0;
        shift_en         = 1'b0;
        stamp_en         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // Status words carry a zero slot and id.
                    pend_kind_next = KIND_STATUS;
                    pend_slot_next = '0;
                    pend_id_next   = '0;
                    case (cmd)
                        CMD_ADD:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                pend_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                add_wr           = 1'b1;
                                count_next       = count_reg + 1'b1;
                                pend_status_next = STATUS_OK;
                            end
                            pend_valid_next = 1'b1;
                            state_next      = S_LAST;
                        end
                        CMD_CLEAR:
                        begin
                            count_next       = '0;
                            pend_status_next = STATUS_OK;
                            pend_valid_next  = 1'b1;
                            state_next       = S_LAST;
                        end
                        CMD_REMOVE:
                        begin
                            key_id_next    = can_id;
                            scan_idx_next  = '0;
                            found_next     = 1'b0;
                            op_remove_next = 1'b1;
                            state_next     = S_SCAN;
                        end
                        CMD_TICK:
                        begin
                            now_next        = now_ms;
                            scan_idx_next   = '0;
                            op_remove_next  = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (scan_idx_reg == count_reg)
                begin
                    if (op_remove_reg)
                    begin
                        pend_kind_next   = KIND_STATUS;
                        pend_slot_next   = '0;
                        pend_id_next     = '0;
                        pend_status_next = found_reg ? STATUS_OK : STATUS_NOT_FOUND;
                        pend_valid_next  = 1'b1;
                        if (found_reg)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    state_next = S_LAST;
                end
                else if (op_remove_reg)
                begin
                    // From the first match onward every cell takes its neighbor's entry.
                    if (found_reg || sel_match)
                    begin
                        shift_en   = 1'b1;
                        found_next = 1'b1;
                    end
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (sel_due)
                begin
                    // A second due entry pushes the held one out; wait if that cannot go.
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = pend_kind_reg;
                            out_status_next = pend_status_reg;
                            out_slot_next   = pend_slot_reg;
                            out_id_next     = pend_id_reg;
                            out_last_next   = 1'b0;
                            out_total_next  = TOTAL_W'(count_reg);
                        end
                        pend_valid_next  = 1'b1;
                        pend_kind_next   = KIND_FRAME;
                        pend_status_next = STATUS_OK;
                        pend_slot_next   = SLOT_W'(scan_idx_reg);
                        pend_id_next     = sel_id;
                        stamp_en         = 1'b1;
                        scan_idx_next    = scan_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_LAST:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_status_next = pend_status_reg;
                    out_slot_next   = pend_slot_reg;
                    out_id_next     = pend_id_reg;
                    out_last_next   = 1'b1;
                    out_total_next  = TOTAL_W'(count_reg);
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            cell_ctrl[i].wr    = add_wr && wr_sel[i];
            cell_ctrl[i].shift = shift_en && sel[i];
            cell_ctrl[i].stamp = stamp_en && sel[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            op_remove_reg  <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            op_remove_reg  <= op_remove_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_id_reg      <= key_id_next;
        now_reg         <= now_next;
        pend_kind_reg   <= pend_kind_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_id_reg     <= pend_id_next;
        out_kind_reg    <= out_kind_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_id_reg      <= out_id_next;
        out_last_reg    <= out_last_next;
        out_total_reg   <= out_total_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign status      = out_status_reg;
    assign due_slot    = out_slot_reg;
    assign due_id      = out_id_reg;
    assign last_of_run = out_last_reg;
    assign entry_total = out_total_reg;

endmodule

@@ rtl/pfs_checker.sv @@
// Port-level checks for the periodic frame scheduler, bound to the top level.
// Depends on pfs_pkg and periodic_frame_scheduler.
module pfs_checker
    import pfs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                kind,
    input logic [STATUS_W-1:0] status,
    input logic [SLOT_W-1:0]   due_slot,
    input logic [ID_W-1:0]     due_id,
    input logic                last_of_run,
    input logic [TOTAL_W-1:0]  entry_total
);

    // The block works on one word at a time, so an accepted word closes the input.
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on the cycle after an accepted word");

    // A command status word is always the only and final result of its command.
    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |-> last_of_run && due_slot == '0 && due_id == '0)
        else $error("status word with a slot, an id or no last flag");

    // A due frame word always carries the ok status.
    a_frame_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_FRAME |-> status == STATUS_OK)
        else $error("due frame word with a non-ok status");

    // A full report is only given when the table holds its full depth.
    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS && status == STATUS_FULL
        |-> entry_total == TOTAL_W'(TABLE_DEPTH))
        else $error("table full reported with a short table");

    // A stalled output word stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(status)
        && $stable(due_slot) && $stable(due_id) && $stable(last_of_run)
        && $stable(entry_total))
        else $error("stalled output word changed");

endmodule

bind periodic_frame_scheduler pfs_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_pfs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .status      (status),
    .due_slot    (due_slot),
    .due_id      (due_id),
    .last_of_run (last_of_run),
    .entry_total (entry_total)
);
